@@ rtl/sme_pkg.sv @@
// Shared types and constants for the stable matching engine.
package sme_pkg;

  // Default and reset values
  localparam int unsigned DEFAULT_MAX_PAIRS = 16;
  localparam logic [4:0]  PAIR_COUNT_RESET  = 5'd16;

  // Operation codes of an input word
  localparam logic [1:0] OP_LOAD_PROP = 2'd0;
  localparam logic [1:0] OP_LOAD_ACC  = 2'd1;
  localparam logic [1:0] OP_RUN       = 2'd2;

  // Controller states
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SELECT,
    ST_PROPOSE,
    ST_CHECK,
    ST_RANK_NEW,
    ST_DECIDE,
    ST_EMIT
  } state_t;

  // Commands from controller to datapath
  typedef struct packed {
    logic load_prop;    // write one proposer preference entry
    logic load_acc;     // write one acceptor rank entry
    logic init;         // start a run: clear match state, fill free queue
    logic propose;      // read head proposer's next choice, advance his pointer
    logic latch_woman;  // capture the proposed acceptor
    logic check_rank;   // read acceptor's rank of the new proposer
    logic rank_cur_rd;  // capture that rank, read rank of the current partner
    logic retire;       // drop an exhausted proposer from the queue
    logic engage;       // pair the proposer with a free acceptor
    logic swap;         // replace the current partner, requeue him
    logic emit_next;    // advance to the next output pair
  } cmd_t;

  // Status from datapath to controller
  typedef struct packed {
    logic queue_empty;
    logic n_zero;
    logic exhausted;
    logic woman_out;
    logic woman_free;
    logic new_better;
    logic emit_last;
  } status_t;

endpackage

@@ rtl/sme_ctrl.sv @@
// Controller state machine for the stable matching engine.
module sme_ctrl (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  input  logic [1:0]       operation,
  input  logic             out_stall,
  input  sme_pkg::status_t status,
  output sme_pkg::cmd_t    cmd,
  output logic             in_stall,
  output logic             out_valid
);
  import sme_pkg::*;

  state_t state;
  state_t state_next;

  // State register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Next state
  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (in_valid && operation == OP_RUN) begin
          state_next = ST_SELECT;
        end
      end
      ST_SELECT: begin
        if (status.queue_empty) begin
          state_next = status.n_zero ? ST_IDLE : ST_EMIT;
        end else if (!status.exhausted) begin
          state_next = ST_PROPOSE;
        end
      end
      ST_PROPOSE: begin
        state_next = ST_CHECK;
      end
      ST_CHECK: begin
        if (status.woman_out || status.woman_free) begin
          state_next = ST_SELECT;
        end else begin
          state_next = ST_RANK_NEW;
        end
      end
      ST_RANK_NEW: begin
        state_next = ST_DECIDE;
      end
      ST_DECIDE: begin
        state_next = ST_SELECT;
      end
      ST_EMIT: begin
        if (!out_stall && status.emit_last) begin
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  // Outputs
  always_comb begin
    cmd       = '0;
    in_stall  = 1'b1;
    out_valid = 1'b0;
    case (state)
      ST_IDLE: begin
        in_stall      = 1'b0;
        cmd.load_prop = in_valid && operation == OP_LOAD_PROP;
        cmd.load_acc  = in_valid && operation == OP_LOAD_ACC;
        cmd.init      = in_valid && operation == OP_RUN;
      end
      ST_SELECT: begin
        cmd.retire  = !status.queue_empty && status.exhausted;
        cmd.propose = !status.queue_empty && !status.exhausted;
      end
      ST_PROPOSE: begin
        cmd.latch_woman = 1'b1;
      end
      ST_CHECK: begin
        cmd.engage     = !status.woman_out && status.woman_free;
        cmd.check_rank = !status.woman_out && !status.woman_free;
      end
      ST_RANK_NEW: begin
        cmd.rank_cur_rd = 1'b1;
      end
      ST_DECIDE: begin
        cmd.swap = status.new_better;
      end
      ST_EMIT: begin
        out_valid     = 1'b1;
        cmd.emit_next = !out_stall && !status.emit_last;
      end
      default: begin
        in_stall = 1'b1;
      end
    endcase
  end

endmodule

@@ rtl/sme_datapath.sv @@
// Datapath of the stable matching engine: tables, match state, free queue.
module sme_datapath #(
  parameter int unsigned MAX_PAIRS = sme_pkg::DEFAULT_MAX_PAIRS
) (
  input  logic             clk,
  input  logic             rst,
  input  sme_pkg::cmd_t    cmd,
  output sme_pkg::status_t status,
  input  logic             cfg_write,
  input  logic [4:0]       cfg_data,
  input  logic [3:0]       person,
  input  logic [3:0]       position,
  input  logic [3:0]       partner,
  output logic [3:0]       proposer,
  output logic [3:0]       acceptor,
  output logic             last
);
  import sme_pkg::*;

  localparam int unsigned PW    = $clog2(MAX_PAIRS);
  localparam int unsigned CW    = $clog2(MAX_PAIRS + 1);
  localparam int unsigned DEPTH = MAX_PAIRS * MAX_PAIRS;
  localparam int unsigned AW    = $clog2(DEPTH);

  // Table address of row r, column c
  function automatic logic [AW-1:0] tab_addr(input logic [PW-1:0] r, input logic [PW-1:0] c);
    logic [31:0] a;
    a = 32'(r) * MAX_PAIRS + 32'(c);
    return a[AW-1:0];
  endfunction

  // Configuration
  logic [4:0]    pair_count;
  logic [CW-1:0] n_eff;
  logic [CW-1:0] n_run;

  // Preference and rank tables
  logic [3:0]    pref_mem [DEPTH];
  logic [3:0]    rank_mem [DEPTH];
  logic [3:0]    pref_rdata;
  logic [3:0]    rank_rdata;
  logic [AW-1:0] rank_raddr;

  // Match state
  logic [CW-1:0] next_choice      [MAX_PAIRS];
  logic [PW-1:0] acceptor_partner [MAX_PAIRS];
  logic          acceptor_free    [MAX_PAIRS];
  logic [3:0]    proposer_partner [MAX_PAIRS];

  // Free queue
  logic [PW-1:0] free_queue [MAX_PAIRS];
  logic [PW-1:0] head;
  logic [PW-1:0] head_inc;
  logic [CW-1:0] fill;
  logic [PW-1:0] tail;
  logic [31:0]   tail_sum;
  logic [PW-1:0] head_man;

  // Proposal working registers
  logic [PW-1:0] man;
  logic [3:0]    woman;
  logic [PW-1:0] woman_idx;
  logic [PW-1:0] cur;
  logic [3:0]    rank_new;
  logic [PW-1:0] emit_idx;

  // Config register and effective size
  always_ff @(posedge clk) begin
    if (rst) begin
      pair_count <= PAIR_COUNT_RESET;
    end else if (cfg_write) begin
      pair_count <= cfg_data;
    end
  end

  assign n_eff = (32'(pair_count) < MAX_PAIRS) ? CW'(pair_count) : CW'(MAX_PAIRS);

  // Preference table: load port and proposal read port
  always_ff @(posedge clk) begin
    if (cmd.load_prop && 32'(person) < MAX_PAIRS && 32'(position) < MAX_PAIRS) begin
      pref_mem[tab_addr(PW'(person), PW'(position))] <= partner;
    end
    if (cmd.propose) begin
      pref_rdata <= pref_mem[tab_addr(head_man, PW'(next_choice[head_man]))];
    end
  end

  // Rank table: load port and compare read port
  assign rank_raddr = cmd.check_rank ? tab_addr(woman_idx, man) : tab_addr(woman_idx, cur);

  always_ff @(posedge clk) begin
    if (cmd.load_acc && 32'(person) < MAX_PAIRS && 32'(partner) < MAX_PAIRS
        && 32'(position) < MAX_PAIRS) begin
      rank_mem[tab_addr(PW'(person), PW'(partner))] <= position;
    end
    if (cmd.check_rank || cmd.rank_cur_rd) begin
      rank_rdata <= rank_mem[rank_raddr];
    end
  end

  // Queue pointers
  assign head_man  = free_queue[head];
  assign head_inc  = (32'(head) == MAX_PAIRS - 1) ? '0 : PW'(32'(head) + 1);
  assign tail_sum  = 32'(head) + 32'(fill);
  assign tail      = (tail_sum >= MAX_PAIRS) ? PW'(tail_sum - MAX_PAIRS) : PW'(tail_sum);
  assign woman_idx = PW'(woman);

  // Run state updates
  always_ff @(posedge clk) begin
    if (cmd.init) begin
      n_run    <= n_eff;
      head     <= '0;
      fill     <= n_eff;
      emit_idx <= '0;
      for (int i = 0; i < MAX_PAIRS; i++) begin
        free_queue[i]       <= PW'(i);
        next_choice[i]      <= '0;
        acceptor_free[i]    <= 1'b1;
        proposer_partner[i] <= '0;
      end
    end
    // Send the head proposer to his next choice
    if (cmd.propose) begin
      man                   <= head_man;
      next_choice[head_man] <= next_choice[head_man] + 1'b1;
    end
    if (cmd.latch_woman) begin
      woman <= pref_rdata;
    end
    if (cmd.check_rank) begin
      cur <= acceptor_partner[woman_idx];
    end
    if (cmd.rank_cur_rd) begin
      rank_new <= rank_rdata;
    end
    // Drop an exhausted proposer, unmatched
    if (cmd.retire) begin
      proposer_partner[head_man] <= '0;
      head                       <= head_inc;
      fill                       <= fill - 1'b1;
    end
    // Engage with a free acceptor
    if (cmd.engage) begin
      acceptor_free[woman_idx]    <= 1'b0;
      acceptor_partner[woman_idx] <= man;
      proposer_partner[man]       <= woman;
      head                        <= head_inc;
      fill                        <= fill - 1'b1;
    end
    // Replace the current partner and requeue him at the tail
    if (cmd.swap) begin
      free_queue[tail]            <= cur;
      acceptor_partner[woman_idx] <= man;
      proposer_partner[man]       <= woman;
      head                        <= head_inc;
    end
    if (cmd.emit_next) begin
      emit_idx <= emit_idx + 1'b1;
    end
  end

  // Status to controller
  always_comb begin
    status.queue_empty = fill == '0;
    status.n_zero      = n_run == '0;
    status.exhausted   = next_choice[head_man] >= n_run;
    status.woman_out   = 32'(woman) >= 32'(n_run);
    status.woman_free  = acceptor_free[woman_idx];
    status.new_better  = rank_new < rank_rdata;
    status.emit_last   = 32'(emit_idx) + 1 == 32'(n_run);
  end

  // Output word
  assign proposer = 4'(emit_idx);
  assign acceptor = proposer_partner[emit_idx];
  assign last     = status.emit_last;

endmodule

@@ rtl/stable_matching_engine.sv @@
// Top level of the stable matching engine: controller plus datapath.
// Load words are taken one per cycle, and only while the engine is idle.
// Run: an exhausted proposer is retired in the select state; a proposal to a free
// or out-of-range acceptor passes select, propose and check, and one to an engaged
// acceptor also rank_new and decide (two rank reads through the single rank table port); at most N*N proposals.
// Then N result words, one per cycle while not stalled; no input is taken meanwhile.
// Synchronous reset returns to idle with pair_count = 16; tables stay unwritten.
module stable_matching_engine #(
  parameter int unsigned MAX_PAIRS = sme_pkg::DEFAULT_MAX_PAIRS
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       cfg_write,
  input  logic [4:0] cfg_data,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [1:0] operation,
  input  logic [3:0] person,
  input  logic [3:0] position,
  input  logic [3:0] partner,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [3:0] proposer,
  output logic [3:0] acceptor,
  output logic       last
);
  import sme_pkg::*;

  cmd_t    cmd;
  status_t status;

  sme_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .operation (operation),
    .out_stall (out_stall),
    .status    (status),
    .cmd       (cmd),
    .in_stall  (in_stall),
    .out_valid (out_valid)
  );

  sme_datapath #(
    .MAX_PAIRS (MAX_PAIRS)
  ) u_datapath (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .status    (status),
    .cfg_write (cfg_write),
    .cfg_data  (cfg_data),
    .person    (person),
    .position  (position),
    .partner   (partner),
    .proposer  (proposer),
    .acceptor  (acceptor),
    .last      (last)
  );

  // No input word is taken while results are pending
  a_emit_blocks_input: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> in_stall)
    else $error("input taken while emitting results");

  // A run word always makes the engine stall input in the cycle after it is taken
  a_run_stalls: assert property (@(posedge clk) disable iff (rst)
    (in_valid && !in_stall && operation == OP_RUN) |=> in_stall)
    else $error("engine idle right after run word");

  // Results end after the last pair
  a_last_ends: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_stall && last) |=> !out_valid)
    else $error("result after last pair");

  // Results start with proposer zero
  a_first_pair: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> proposer == 4'd0)
    else $error("first pair is not proposer zero");

endmodule
